// ===== sv/rrld_pkg.sv =====
// rrld_pkg: types, codes and the ascii byte class table of the ray level decoder
// used by every module of the block; depends on nothing

package rrld_pkg;

  localparam int MAX_BINS_DEF = 4096;
  localparam int CFG_W        = 13;
  localparam logic [CFG_W-1:0] BINS_RESET = 13'd4096;
  localparam logic [12:0] COUNT_CAP = 13'd8191;

  typedef enum logic [1:0] {
    ACT_DATA  = 2'd0,
    ACT_ASCII = 2'd1,
    ACT_BIN   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    RK_RUN = 2'd0,
    RK_END = 2'd1,
    RK_ERR = 2'd2
  } rkind_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_ABS     = 3'd1,
    ERR_RUN     = 3'd2,
    ERR_DELTA   = 3'd3,
    ERR_INVALID = 3'd4
  } err_t;

  // top two bits of a class byte
  typedef enum logic [1:0] {
    CK_OTHER = 2'd0,
    CK_VAL   = 2'd1,
    CK_DIGIT = 2'd2,
    CK_DELTA = 2'd3
  } ckind_t;

  typedef struct packed {
    rkind_t      kind;
    logic [7:0]  level;
    logic [11:0] first_bin;
    logic [12:0] run_length;
    err_t        error_code;
  } res_t;

  // decoder state apart from the bin position, whose width follows MAX_BINS
  typedef struct packed {
    logic        binary_form;
    logic [7:0]  previous_level;
    logic [12:0] pending_count;
    logic        count_active;
    logic        awaiting_count;
    logic        run_value;
    logic        delta_spill;
    logic        halted;
  } st_t;

  localparam logic [7:0] TN = 8'h00;
  localparam logic [7:0] TT = 8'h01;

  function automatic logic [7:0] tv(int n);
    return 8'(32'h40 | n);
  endfunction

  function automatic logic [7:0] td(int n);
    return 8'(32'h80 | n);
  endfunction

  function automatic logic [7:0] tx(int a, int b);
    return 8'(32'hC0 | ((a + 3) * 7 + (b + 3)));
  endfunction

  // class of bytes 0x00..0x7f; upper half bytes are absolute levels
  localparam logic [7:0] LOW_CLASS [128] = '{
    TT, TN, TN, TN, TN, TN, TN, TN,
    TN, TN, TT, TN, TN, TT, TN, TN,
    TN, TN, TN, TN, TN, TN, TN, TN,
    TN, TN, TN, TN, TN, TN, TN, TN,
    TN, tx(-3,-3), tv(16), TN, tx(-3,3), TN, tx(3,3), tv(17),
    tx(-3,2), tx(3,2), tv(18), tx(1,0), tv(19), tx(-1,0), tx(0,0), tx(-3,-2),
    td(0), td(1), td(2), td(3), td(4), td(5), td(6), td(7),
    td(8), td(9), tv(20), tv(21), tx(0,-1), tv(22), tx(0,1), tv(23),
    tx(3,-3), tv(0), tv(1), tv(2), tv(3), tv(4), tv(5), tv(6),
    tv(7), tv(8), tv(9), tv(10), tv(11), tv(12), tv(13), tv(14),
    tv(15), tv(24), tv(25), tx(-1,2), tx(0,2), tx(1,2), tx(2,2), tx(-1,3),
    tx(0,3), tx(1,3), tv(26), tx(-2,-3), tx(3,-2), tx(2,-3), tv(27), tv(28),
    TN, tx(-1,-3), tx(0,-3), tx(1,-3), tx(-2,-2), tx(-1,-2), tx(0,-2), tx(1,-2),
    tx(2,-2), tx(-3,-1), tx(-2,-1), tx(-1,-1), tx(1,-1), tx(2,-1), tx(3,-1), tx(-3,0),
    tx(-2,0), tx(2,0), tx(3,0), tx(-3,1), tx(-2,1), tx(-1,1), tx(1,1), tx(2,1),
    tx(3,1), tx(-2,2), tv(29), tx(-2,3), tv(30), tx(2,3), tv(31), TN
  };

  // first half of a delta pair code (code / 7), code below 49
  function automatic logic [2:0] delta_hi(logic [5:0] v);
    logic [2:0] h;
    if (v >= 6'd42)      h = 3'd6;
    else if (v >= 6'd35) h = 3'd5;
    else if (v >= 6'd28) h = 3'd4;
    else if (v >= 6'd21) h = 3'd3;
    else if (v >= 6'd14) h = 3'd2;
    else if (v >= 6'd7)  h = 3'd1;
    else                 h = 3'd0;
    return h;
  endfunction

  function automatic res_t mk_res(rkind_t k, logic [7:0] lvl, logic [11:0] first,
                                  logic [12:0] len, err_t e);
    res_t r;
    r.kind       = k;
    r.level      = lvl;
    r.first_bin  = first;
    r.run_length = len;
    r.error_code = e;
    return r;
  endfunction

endpackage

// ===== sv/rrld_in_if.sv =====
// rrld_in_if: input channel of the ray level decoder, one byte item per transfer
// no dependencies

interface rrld_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] code_byte;

  modport source (output valid, output action, output code_byte, input ready);
  modport sink   (input valid, input action, input code_byte, output ready);
endinterface

// ===== sv/rrld_out_if.sv =====
// rrld_out_if: result channel of the ray level decoder, one run, end or error per item
// no dependencies

interface rrld_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  level;
  logic [11:0] first_bin;
  logic [12:0] run_length;
  logic [2:0]  error_code;
  logic        last_of_item;

  modport source (output valid, output kind, output level, output first_bin,
                  output run_length, output error_code, output last_of_item,
                  input ready);
  modport sink   (input valid, input kind, input level, input first_bin,
                  input run_length, input error_code, input last_of_item,
                  output ready);
endinterface

// ===== sv/rrld_decode.sv =====
// rrld_decode: single pass decode of one byte item into up to three results
// and the next decoder state; depends on rrld_pkg

module rrld_decode #(
  parameter int MAX_BINS = rrld_pkg::MAX_BINS_DEF,
  parameter int POS_W    = $clog2(MAX_BINS + 1)
) (
  input  logic [1:0]                    action,
  input  logic [7:0]                    code_byte,
  input  logic [rrld_pkg::CFG_W-1:0]    bins_per_ray,
  input  rrld_pkg::st_t                 st,
  input  logic [POS_W-1:0]              pos,
  output rrld_pkg::st_t                 st_nxt,
  output logic [POS_W-1:0]              pos_nxt,
  output rrld_pkg::res_t [2:0]          res,
  output logic [1:0]                    res_cnt
);
  import rrld_pkg::*;

  localparam int CW = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;
  localparam logic [CW-1:0] MAXB = CW'(MAX_BINS);

  logic [7:0]    cls;
  ckind_t        ckind;
  logic          term;
  logic [7:0]    lvl_abs;
  logic [5:0]    code_v;
  logic [2:0]    d_hi;
  logic [2:0]    d_lo;
  logic [CW-1:0] lim;
  logic [CW-1:0] cfg_c;

  always_comb begin
    cls     = LOW_CLASS[code_byte[6:0]];
    term    = !code_byte[7] && (cls == TT);
    ckind   = code_byte[7] ? CK_VAL : ckind_t'(cls[7:6]);
    lvl_abs = code_byte[7] ? (code_byte - 8'h60) : {2'b00, cls[5:0]};
    code_v  = cls[5:0];
    d_hi    = delta_hi(code_v);
    d_lo    = 3'(code_v - ((6'(d_hi) << 3) - 6'(d_hi)));
    cfg_c   = CW'(bins_per_ray);
    lim     = (cfg_c > MAXB) ? MAXB : cfg_c;
  end

  logic [CW-1:0] pos_v;
  logic [1:0]    n_v;
  logic          stop;
  logic [7:0]    lvl1;
  logic [7:0]    lvl2;
  logic [16:0]   cnt_mul;

  always_comb begin
    st_nxt  = st;
    res     = '0;
    n_v     = 2'd0;
    stop    = 1'b0;
    pos_v   = CW'(pos);
    lvl1    = st.previous_level + 8'(d_hi) + 8'd253;
    lvl2    = lvl1 + 8'(d_lo) + 8'd253;
    cnt_mul = 17'(st.pending_count) * 17'd10 + 17'(code_v);

    case (action)
      ACT_ASCII, ACT_BIN: begin
        st_nxt             = '0;
        st_nxt.binary_form = (action == ACT_BIN);
        pos_v              = '0;
      end
      ACT_DATA: begin
        if (!st.halted && st.binary_form) begin
          if (st.awaiting_count) begin
            st_nxt.awaiting_count = 1'b0;
            if (code_byte == 8'd0) begin
              res[0] = mk_res(RK_END, 8'd0, 12'd0, 13'd0, ERR_NONE);
              n_v = 2'd1;
              st_nxt.halted = 1'b1;
            end else if (pos_v + CW'(code_byte) > lim) begin
              res[0] = mk_res(RK_ERR, 8'd0, 12'd0, 13'd0, ERR_RUN);
              n_v = 2'd1;
              st_nxt.halted = 1'b1;
            end else begin
              res[0] = mk_res(RK_RUN, {7'd0, st.run_value}, pos_v[11:0],
                              13'(code_byte), ERR_NONE);
              n_v = 2'd1;
              pos_v = pos_v + CW'(code_byte);
            end
          end else if (code_byte <= 8'd1) begin
            st_nxt.run_value      = code_byte[0];
            st_nxt.awaiting_count = 1'b1;
          end else if (pos_v >= lim) begin
            res[0] = mk_res(RK_ERR, 8'd0, 12'd0, 13'd0, ERR_ABS);
            n_v = 2'd1;
            st_nxt.halted = 1'b1;
          end else begin
            res[0] = mk_res(RK_RUN, code_byte, pos_v[11:0], 13'd1, ERR_NONE);
            n_v = 2'd1;
            pos_v = pos_v + CW'(1);
          end
        end else if (!st.halted) begin
          // a spilled delta must be followed by a terminator
          if (st.delta_spill) begin
            st_nxt.delta_spill = 1'b0;
            if (!term) begin
              res[0] = mk_res(RK_ERR, 8'd0, 12'd0, 13'd0, ERR_DELTA);
              n_v = 2'd1;
              st_nxt.halted = 1'b1;
              stop = 1'b1;
            end
          end
          // flush the pending run on any non-digit byte
          if (!stop && st.count_active && ckind != CK_DIGIT) begin
            st_nxt.count_active  = 1'b0;
            st_nxt.pending_count = '0;
            if (pos_v + CW'(st.pending_count) > lim) begin
              res[0] = mk_res(RK_ERR, 8'd0, 12'd0, 13'd0, ERR_RUN);
              n_v = 2'd1;
              st_nxt.halted = 1'b1;
              stop = 1'b1;
            end else if (st.pending_count != 13'd0) begin
              res[0] = mk_res(RK_RUN, st.previous_level, pos_v[11:0],
                              st.pending_count, ERR_NONE);
              n_v = 2'd1;
              pos_v = pos_v + CW'(st.pending_count);
            end
          end
          if (!stop) begin
            case (ckind)
              CK_VAL: begin
                if (pos_v >= lim) begin
                  res[n_v] = mk_res(RK_ERR, 8'd0, 12'd0, 13'd0, ERR_ABS);
                  st_nxt.halted = 1'b1;
                end else begin
                  st_nxt.previous_level = lvl_abs;
                  res[n_v] = mk_res(RK_RUN, lvl_abs, pos_v[11:0], 13'd1, ERR_NONE);
                  pos_v = pos_v + CW'(1);
                end
                n_v = n_v + 2'd1;
              end
              CK_DIGIT: begin
                if (st.count_active) begin
                  st_nxt.pending_count = (cnt_mul > 17'(COUNT_CAP)) ? COUNT_CAP
                                                                    : cnt_mul[12:0];
                end else begin
                  st_nxt.count_active  = 1'b1;
                  st_nxt.pending_count = 13'(code_v);
                end
              end
              CK_DELTA: begin
                if (pos_v >= lim) begin
                  res[n_v] = mk_res(RK_ERR, 8'd0, 12'd0, 13'd0, ERR_DELTA);
                  n_v = n_v + 2'd1;
                  st_nxt.halted = 1'b1;
                end else begin
                  res[n_v] = mk_res(RK_RUN, lvl1, pos_v[11:0], 13'd1, ERR_NONE);
                  n_v = n_v + 2'd1;
                  pos_v = pos_v + CW'(1);
                  st_nxt.previous_level = lvl1;
                  if (pos_v < lim) begin
                    res[n_v] = mk_res(RK_RUN, lvl2, pos_v[11:0], 13'd1, ERR_NONE);
                    n_v = n_v + 2'd1;
                    pos_v = pos_v + CW'(1);
                    st_nxt.previous_level = lvl2;
                  end else begin
                    st_nxt.delta_spill = 1'b1;
                  end
                end
              end
              default: begin
                if (term) begin
                  res[n_v] = mk_res(RK_END, 8'd0, 12'd0, 13'd0, ERR_NONE);
                end else begin
                  res[n_v] = mk_res(RK_ERR, 8'd0, 12'd0, 13'd0, ERR_INVALID);
                end
                n_v = n_v + 2'd1;
                st_nxt.halted = 1'b1;
              end
            endcase
          end
        end
      end
      default: ;
    endcase

    pos_nxt = POS_W'(pos_v);
    res_cnt = n_v;
  end

endmodule

// ===== sv/rrld_emit.sv =====
// rrld_emit: result buffer that holds the results of one item and sends them
// one per cycle while out_ch is ready; depends on rrld_pkg and rrld_out_if

module rrld_emit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  rrld_pkg::res_t [2:0]   load_res,
  input  logic [1:0]             load_cnt,
  output logic                   free,
  rrld_out_if.source             out_ch
);
  import rrld_pkg::*;

  res_t [2:0] res_r;
  logic [1:0] cnt_r;
  logic [1:0] idx_r;
  logic       last;
  logic       fire;

  assign last = (idx_r == cnt_r - 2'd1);
  assign fire = out_ch.valid && out_ch.ready;
  // buffer can take the next item when empty or sending its last result now
  assign free = (cnt_r == 2'd0) || (fire && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load && free) begin
      cnt_r <= load_cnt;
      idx_r <= 2'd0;
    end else if (fire) begin
      if (last) begin
        cnt_r <= 2'd0;
        idx_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      res_r <= load_res;
    end
  end

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.kind         = res_r[idx_r].kind;
  assign out_ch.level        = res_r[idx_r].level;
  assign out_ch.first_bin    = res_r[idx_r].first_bin;
  assign out_ch.run_length   = res_r[idx_r].run_length;
  assign out_ch.error_code   = res_r[idx_r].error_code;
  assign out_ch.last_of_item = last;

endmodule

// ===== sv/radar_ray_level_decoder_unit.sv =====
// radar_ray_level_decoder_unit: top level of the ray level decoder; input
// register, decoder state and bin limit register; uses rrld_pkg, rrld_in_if,
// rrld_out_if, rrld_decode and rrld_emit
//
//  port     dir  handshake        carries
//  in_ch    in   valid / ready    action, code_byte
//  out_ch   out  valid / ready    kind, level, first_bin, run_length, error_code,
//                                 last_of_item
//  cfg_*    in   cfg_we           cfg_wdata = bins_per_ray
//
// a byte item is registered, then decoded in one pass into the result buffer;
// results leave one per cycle while out_ch is ready, over the single result port;
// a byte with results waits for a free buffer, a byte with none never waits
// rst_n is synchronous: the decoder halts until the first start item, limit 4096
// a stalled out_ch holds the buffer; one more item waits in the input register

module radar_ray_level_decoder_unit #(
  parameter int MAX_BINS = rrld_pkg::MAX_BINS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  rrld_in_if.sink                    in_ch,
  rrld_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [rrld_pkg::CFG_W-1:0] cfg_wdata
);
  import rrld_pkg::*;

  localparam int POS_W = $clog2(MAX_BINS + 1);

  logic             ir_valid_r;
  logic [1:0]       ir_action_r;
  logic [7:0]       ir_byte_r;
  logic [CFG_W-1:0] bins_r;
  st_t              st_r;
  st_t              st_nxt;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  res_t [2:0]       dec_res;
  logic [1:0]       dec_cnt;
  logic             buf_free;
  logic             go;

  // items without results never wait for the buffer
  assign go          = ir_valid_r && ((dec_cnt == 2'd0) || buf_free);
  assign in_ch.ready = !ir_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      ir_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      ir_action_r <= in_ch.action;
      ir_byte_r   <= in_ch.code_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r <= BINS_RESET;
    end else if (cfg_we) begin
      bins_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '{halted: 1'b1, default: '0};
      pos_r <= '0;
    end else if (go) begin
      st_r  <= st_nxt;
      pos_r <= pos_nxt;
    end
  end

  rrld_decode #(
    .MAX_BINS (MAX_BINS),
    .POS_W    (POS_W)
  ) u_decode (
    .action       (ir_action_r),
    .code_byte    (ir_byte_r),
    .bins_per_ray (bins_r),
    .st           (st_r),
    .pos          (pos_r),
    .st_nxt       (st_nxt),
    .pos_nxt      (pos_nxt),
    .res          (dec_res),
    .res_cnt      (dec_cnt)
  );

  rrld_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (go && (dec_cnt != 2'd0)),
    .load_res (dec_res),
    .load_cnt (dec_cnt),
    .free     (buf_free),
    .out_ch   (out_ch)
  );

endmodule
